// ----- sv/etok_pkg.sv -----
`default_nettype none
package etok_pkg;

	localparam int OffsetBitsDefault = 16;

	localparam int KindW = 4;
	localparam int OffW  = 16;
	localparam int LenW  = 16;
	localparam int ErrW  = 3;
	localparam int UnitW = 16;
	localparam int MaxResults = 3;

	// token kinds
	localparam logic [KindW-1:0] TK_NUMBER   = 4'd0;
	localparam logic [KindW-1:0] TK_IDENT    = 4'd1;
	localparam logic [KindW-1:0] TK_CONST    = 4'd2;
	localparam logic [KindW-1:0] TK_FUNC     = 4'd3;
	localparam logic [KindW-1:0] TK_PLUS     = 4'd4;
	localparam logic [KindW-1:0] TK_MINUS    = 4'd5;
	localparam logic [KindW-1:0] TK_MULTIPLY = 4'd6;
	localparam logic [KindW-1:0] TK_DIVIDE   = 4'd7;
	localparam logic [KindW-1:0] TK_POWER    = 4'd8;
	localparam logic [KindW-1:0] TK_LPAREN   = 4'd9;
	localparam logic [KindW-1:0] TK_RPAREN   = 4'd10;
	localparam logic [KindW-1:0] TK_LBRACKET = 4'd11;
	localparam logic [KindW-1:0] TK_RBRACKET = 4'd12;
	localparam logic [KindW-1:0] TK_EQUAL    = 4'd13;
	localparam logic [KindW-1:0] TK_COMMA    = 4'd14;
	localparam logic [KindW-1:0] TK_END      = 4'd15;

	// error codes
	localparam logic [ErrW-1:0] ERR_OK        = 3'd0;
	localparam logic [ErrW-1:0] ERR_EMPTY     = 3'd1;
	localparam logic [ErrW-1:0] ERR_BAD_CHAR  = 3'd2;
	localparam logic [ErrW-1:0] ERR_DOT_DIGIT = 3'd3;
	localparam logic [ErrW-1:0] ERR_EXP_DIGIT = 3'd4;
	localparam logic [ErrW-1:0] ERR_TOO_LONG  = 3'd5;

	// scan modes
	localparam logic [3:0] M_IDLE    = 4'd0;
	localparam logic [3:0] M_INT     = 4'd1;
	localparam logic [3:0] M_DOT     = 4'd2;
	localparam logic [3:0] M_FRAC    = 4'd3;
	localparam logic [3:0] M_EXP     = 4'd4;
	localparam logic [3:0] M_EXPSIGN = 4'd5;
	localparam logic [3:0] M_EXPDIG  = 4'd6;
	localparam logic [3:0] M_ID      = 4'd7;
	localparam logic [3:0] M_ID_C    = 4'd8;
	localparam logic [3:0] M_ID_F    = 4'd9;
	localparam logic [3:0] M_SKIP    = 4'd10;

	localparam logic [2:0] KwConstLen = 3'd5;
	localparam logic [2:0] KwFuncLen  = 3'd4;

	typedef struct packed {
		logic [KindW-1:0] kind;
		logic [OffW-1:0]  offset;
		logic [LenW-1:0]  length;
		logic [ErrW-1:0]  err;
		logic             last;
	} result_t;

	typedef struct packed {
		logic    emit;
		logic    fail;
		result_t res;
	} close_t;

	function automatic logic is_digit(logic [UnitW-1:0] c);
		return c >= 16'h0030 && c <= 16'h0039;
	endfunction

	function automatic logic is_word_start(logic [UnitW-1:0] c);
		return (c >= 16'h0041 && c <= 16'h005A) || (c >= 16'h0061 && c <= 16'h007A) ||
			c == 16'h005F;
	endfunction

	function automatic logic is_ws(logic [UnitW-1:0] c);
		return (c >= 16'h0009 && c <= 16'h000D) || c == 16'h0020 || c == 16'h0085 ||
			c == 16'h00A0 || c == 16'h1680 || (c >= 16'h2000 && c <= 16'h200A) ||
			c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
			c == 16'h3000;
	endfunction

	// {hit, kind} for one-unit tokens
	function automatic logic [KindW:0] single_kind(logic [UnitW-1:0] c);
		logic [KindW:0] r;
		case (c)
			16'h002B: r = {1'b1, TK_PLUS};
			16'h002D, 16'h2013, 16'h2212, 16'h2014: r = {1'b1, TK_MINUS};
			16'h002A, 16'h00D7: r = {1'b1, TK_MULTIPLY};
			16'h002F, 16'h00F7: r = {1'b1, TK_DIVIDE};
			16'h005E: r = {1'b1, TK_POWER};
			16'h0028: r = {1'b1, TK_LPAREN};
			16'h0029: r = {1'b1, TK_RPAREN};
			16'h005B: r = {1'b1, TK_LBRACKET};
			16'h005D: r = {1'b1, TK_RBRACKET};
			16'h003D: r = {1'b1, TK_EQUAL};
			16'h002C: r = {1'b1, TK_COMMA};
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [UnitW-1:0] kw_const_at(logic [2:0] k);
		logic [UnitW-1:0] r;
		case (k)
			3'd0: r = 16'h0063;
			3'd1: r = 16'h006F;
			3'd2: r = 16'h006E;
			3'd3: r = 16'h0073;
			3'd4: r = 16'h0074;
			default: r = 16'hFFFF;
		endcase
		return r;
	endfunction

	function automatic logic [UnitW-1:0] kw_func_at(logic [2:0] k);
		logic [UnitW-1:0] r;
		case (k)
			3'd0: r = 16'h0066;
			3'd1: r = 16'h0075;
			3'd2: r = 16'h006E;
			3'd3: r = 16'h0063;
			default: r = 16'hFFFF;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- sv/etok_unit_if.sv -----
`default_nettype none
interface etok_unit_if;
	logic                        valid;
	logic                        ready;
	logic [etok_pkg::UnitW-1:0]  code_unit;
	logic                        last_unit;

	modport source(output valid, output code_unit, output last_unit, input ready);
	modport sink(input valid, input code_unit, input last_unit, output ready);
endinterface
`default_nettype wire

// ----- sv/etok_token_if.sv -----
`default_nettype none
interface etok_token_if;
	logic                        valid;
	logic                        ready;
	logic [etok_pkg::KindW-1:0]  token_kind;
	logic [etok_pkg::OffW-1:0]   start_offset;
	logic [etok_pkg::LenW-1:0]   token_length;
	logic [etok_pkg::ErrW-1:0]   error_code;
	logic                        last_token;

	modport source(output valid, output token_kind, output start_offset, output token_length,
		output error_code, output last_token, input ready);
	modport sink(input valid, input token_kind, input start_offset, input token_length,
		input error_code, input last_token, output ready);
endinterface
`default_nettype wire

// ----- sv/expression_tokenizer_top.sv -----
`default_nettype none
// channel   dir  payload                                              request
// unit_ch   in   code_unit[15:0] last_unit                            valid & ready
// token_ch  out  token_kind[3:0] start_offset[15:0] token_length[15:0] valid & ready
//                error_code[2:0] last_token
//
// one code unit per clock while the result register keeps up: a unit is first held in the
// input register, then the scanner updates its state and loads all results of that unit
// (up to three) at once. results leave one per cycle while token_ch is ready; a unit with
// two or three results holds the input while the result register drains.
// arst_n clears the scanner to idle and empties both registers.
// a stalled token_ch holds the input register, and from there unit_ch.ready.
module expression_tokenizer_top #(
	parameter int OFFSET_BITS = etok_pkg::OffsetBitsDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	etok_unit_if.sink        unit_ch,
	etok_token_if.source     token_ch
);
	import etok_pkg::*;

	localparam int OB = OFFSET_BITS;

	function automatic logic [OffW-1:0] to16(logic [OB-1:0] x);
		logic [31:0] w;
		w = 32'(x);
		return w[OffW-1:0];
	endfunction

	function automatic result_t err_res(logic [OB-1:0] off, logic [ErrW-1:0] e);
		result_t r;
		r.kind   = TK_NUMBER;
		r.offset = to16(off);
		r.length = '0;
		r.err    = e;
		r.last   = 1'b1;
		return r;
	endfunction

	// ends an open token at offset e
	function automatic close_t close_res(logic [3:0] md, logic [2:0] k, logic [OB-1:0] b,
			logic [OB-1:0] e);
		close_t cr;
		logic [OB-1:0] len;
		cr = '0;
		len = e - b;
		cr.res.kind   = TK_NUMBER;
		cr.res.offset = to16(b);
		cr.res.length = to16(len);
		cr.res.err    = ERR_OK;
		cr.res.last   = 1'b0;
		case (md)
			M_INT, M_FRAC, M_EXPDIG: begin
				cr.emit = 1'b1;
			end
			M_DOT: begin
				cr.emit = 1'b1;
				cr.fail = 1'b1;
				cr.res  = err_res(b, ERR_DOT_DIGIT);
			end
			M_EXP, M_EXPSIGN: begin
				cr.emit = 1'b1;
				cr.fail = 1'b1;
				cr.res  = err_res(b, ERR_EXP_DIGIT);
			end
			M_ID, M_ID_C, M_ID_F: begin
				cr.emit = 1'b1;
				cr.res.kind = TK_IDENT;
				if (md == M_ID_C && k == KwConstLen) cr.res.kind = TK_CONST;
				if (md == M_ID_F && k == KwFuncLen) cr.res.kind = TK_FUNC;
			end
			default: begin
				cr.emit = 1'b0;
			end
		endcase
		return cr;
	endfunction

	// input register
	logic             valid_s1;
	logic [UnitW-1:0] code_s1;
	logic             last_s1;

	// scanner state
	logic [3:0]    mode_q;
	logic [2:0]    kp_q;
	logic [OB-1:0] begin_q;
	logic [OB-1:0] pos_q;
	logic          seen_q;
	logic          pend_q;
	logic [OB-1:0] bso_q;

	// result register
	result_t   res_q [MaxResults];
	logic [1:0] cnt_q;
	logic [1:0] rd_q;

	logic out_fire, last_out, bundle_free, adv, accept;

	// next state and results of the unit in the input register
	logic [3:0]    m_c;
	logic [2:0]    kp_c;
	logic [OB-1:0] begin_c;
	logic [OB-1:0] pos_c;
	logic          seen_c;
	logic          pend_c;
	logic [OB-1:0] bso_c;
	result_t       r_c [MaxResults];
	logic [1:0]    n_c;
	logic          ok_c;

	assign token_ch.valid        = cnt_q != 2'd0;
	assign token_ch.token_kind   = res_q[rd_q].kind;
	assign token_ch.start_offset = res_q[rd_q].offset;
	assign token_ch.token_length = res_q[rd_q].length;
	assign token_ch.error_code   = res_q[rd_q].err;
	assign token_ch.last_token   = res_q[rd_q].last;

	assign out_fire    = token_ch.valid && token_ch.ready;
	assign last_out    = rd_q == cnt_q - 2'd1;
	assign bundle_free = cnt_q == 2'd0 || (out_fire && last_out);
	assign adv         = valid_s1 && bundle_free;
	assign unit_ch.ready = !valid_s1 || bundle_free;
	assign accept      = unit_ch.valid && unit_ch.ready;

	always_comb begin
		logic [OB-1:0]    off;
		logic             cont;
		logic [KindW:0]   sk;
		close_t           cl;
		logic [UnitW-1:0] c;
		c       = code_s1;
		m_c     = mode_q;
		kp_c    = kp_q;
		begin_c = begin_q;
		pos_c   = pos_q;
		seen_c  = seen_q;
		pend_c  = pend_q;
		bso_c   = bso_q;
		n_c     = '0;
		ok_c    = 1'b1;
		off     = pos_q;
		cont    = 1'b0;
		sk      = single_kind(c);
		cl      = '0;
		for (int i = 0; i < MaxResults; i++) r_c[i] = '0;

		if (mode_q != M_SKIP) begin
			if (&pos_q) begin
				r_c[n_c] = err_res(pos_q, ERR_TOO_LONG);
				n_c = n_c + 2'd1;
				ok_c = 1'b0;
			end else begin
				pos_c = pos_q + 1'b1;
				case (mode_q)
					M_INT: begin
						if (is_digit(c)) cont = 1'b1;
						else if (c == 16'h002E) begin
							cont = 1'b1;
							m_c = M_DOT;
						end else if (c == 16'h0065 || c == 16'h0045) begin
							cont = 1'b1;
							m_c = M_EXP;
						end
					end
					M_FRAC: begin
						if (is_digit(c)) cont = 1'b1;
						else if (c == 16'h0065 || c == 16'h0045) begin
							cont = 1'b1;
							m_c = M_EXP;
						end
					end
					M_DOT: begin
						if (is_digit(c)) begin
							cont = 1'b1;
							m_c = M_FRAC;
						end
					end
					M_EXP: begin
						if (is_digit(c)) begin
							cont = 1'b1;
							m_c = M_EXPDIG;
						end else if (c == 16'h002B || c == 16'h002D) begin
							cont = 1'b1;
							m_c = M_EXPSIGN;
						end
					end
					M_EXPSIGN, M_EXPDIG: begin
						if (is_digit(c)) begin
							cont = 1'b1;
							m_c = M_EXPDIG;
						end
					end
					M_ID, M_ID_C, M_ID_F: begin
						if (is_digit(c) || is_word_start(c)) begin
							cont = 1'b1;
							if (mode_q == M_ID_C && kp_q < KwConstLen && c == kw_const_at(kp_q))
								kp_c = kp_q + 3'd1;
							else if (mode_q == M_ID_F && kp_q < KwFuncLen &&
									c == kw_func_at(kp_q))
								kp_c = kp_q + 3'd1;
							else
								m_c = M_ID;
						end
					end
					default: begin
						cont = 1'b0;
					end
				endcase

				if (!cont) begin
					cl = close_res(mode_q, kp_q, begin_q, off);
					if (cl.emit) begin
						r_c[n_c] = cl.res;
						n_c = n_c + 2'd1;
					end
					if (cl.fail) ok_c = 1'b0;
					else m_c = M_IDLE;

					if (ok_c && c != 16'h0020) begin
						if (is_ws(c)) begin
							// stray whitespace only matters if content follows
							if (seen_q && !pend_q) begin
								pend_c = 1'b1;
								bso_c = off;
							end
						end else if (pend_q) begin
							r_c[n_c] = err_res(bso_q, ERR_BAD_CHAR);
							n_c = n_c + 2'd1;
							ok_c = 1'b0;
						end else begin
							seen_c = 1'b1;
							if (is_digit(c)) begin
								m_c = M_INT;
								begin_c = off;
							end else if (is_word_start(c)) begin
								begin_c = off;
								kp_c = 3'd1;
								m_c = (c == 16'h0063) ? M_ID_C : (c == 16'h0066) ? M_ID_F : M_ID;
							end else if (sk[KindW]) begin
								r_c[n_c].kind   = sk[KindW-1:0];
								r_c[n_c].offset = to16(off);
								r_c[n_c].length = 16'd1;
								r_c[n_c].err    = ERR_OK;
								r_c[n_c].last   = 1'b0;
								n_c = n_c + 2'd1;
							end else begin
								r_c[n_c] = err_res(off, ERR_BAD_CHAR);
								n_c = n_c + 2'd1;
								ok_c = 1'b0;
							end
						end
					end
				end
			end

			if (ok_c && last_s1) begin
				cl = close_res(m_c, kp_c, begin_c, pos_c);
				if (cl.emit) begin
					r_c[n_c] = cl.res;
					n_c = n_c + 2'd1;
				end
				if (!cl.fail) begin
					if (!seen_c) r_c[n_c] = err_res('0, ERR_EMPTY);
					else begin
						r_c[n_c].kind   = TK_END;
						r_c[n_c].offset = to16(pos_c);
						r_c[n_c].length = '0;
						r_c[n_c].err    = ERR_OK;
						r_c[n_c].last   = 1'b1;
					end
					n_c = n_c + 2'd1;
				end
			end
		end

		if (last_s1) begin
			m_c     = M_IDLE;
			kp_c    = '0;
			begin_c = '0;
			pos_c   = '0;
			seen_c  = 1'b0;
			pend_c  = 1'b0;
			bso_c   = '0;
		end else if (!ok_c) begin
			m_c = M_SKIP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			code_s1 <= unit_ch.code_unit;
			last_s1 <= unit_ch.last_unit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			kp_q    <= '0;
			begin_q <= '0;
			pos_q   <= '0;
			seen_q  <= 1'b0;
			pend_q  <= 1'b0;
			bso_q   <= '0;
		end else if (adv) begin
			mode_q  <= m_c;
			kp_q    <= kp_c;
			begin_q <= begin_c;
			pos_q   <= pos_c;
			seen_q  <= seen_c;
			pend_q  <= pend_c;
			bso_q   <= bso_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= '0;
		end else if (adv) begin
			cnt_q <= n_c;
			rd_q  <= '0;
		end else if (out_fire) begin
			if (last_out) begin
				cnt_q <= '0;
				rd_q  <= '0;
			end else begin
				rd_q <= rd_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < MaxResults; i++) res_q[i] <= r_c[i];
		end
	end

	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_q <= cnt_q && (cnt_q == 2'd0 || rd_q < cnt_q))
		else $error("read pointer beyond loaded results");

	a_last_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		(token_ch.valid && token_ch.last_token) |-> last_out)
		else $error("result after a last token in the same unit");

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(token_ch.valid && token_ch.error_code != ERR_OK) |-> token_ch.last_token)
		else $error("error result not marked last");

	a_end_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(token_ch.valid && token_ch.token_kind == TK_END) |->
		(token_ch.last_token && token_ch.token_length == '0))
		else $error("malformed end token");

	a_skip_after_err: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !ok_c && !last_s1) |=> mode_q == M_SKIP)
		else $error("scanner not skipping after an error");

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> unit_ch.ready)
		else $error("input stalled with an empty result register");

endmodule
`default_nettype wire

// ----- tb/etok_token_checker.sv -----
`timescale 1ns / 100ps
module etok_token_checker #(
	parameter int OFFSET_BITS = etok_pkg::OffsetBitsDefault
) (
	input  logic  clk,
	input  logic  arst_n,
	etok_unit_if  unit_ch,
	etok_token_if token_ch,
	output int    fail_count,
	output int    waiting
);
	import etok_pkg::*;

	localparam longint unsigned PosMax = (64'd1 << OFFSET_BITS) - 64'd1;

	localparam logic [UnitW-1:0] U_SPACE  = 16'h0020;
	localparam logic [UnitW-1:0] U_DOT    = 16'h002E;
	localparam logic [UnitW-1:0] U_E_LO   = 16'h0065;
	localparam logic [UnitW-1:0] U_E_UP   = 16'h0045;
	localparam logic [UnitW-1:0] U_PLUS   = 16'h002B;
	localparam logic [UnitW-1:0] U_HYPHEN = 16'h002D;

	string const_word = "const";
	string func_word  = "func";

	// scanner copy
	logic [3:0]      scan_state;
	int              kw_count;
	longint unsigned tok_start;
	longint unsigned unit_pos;
	bit              seen_text;
	bit              blank_held;
	longint unsigned blank_at;

	result_t token_queue[$];

	initial begin
		fail_count = 0;
		waiting    = 0;
	end

	function automatic bit num_char(logic [UnitW-1:0] c);
		return c >= 16'h0030 && c <= 16'h0039;
	endfunction

	function automatic bit letter_char(logic [UnitW-1:0] c);
		return (c >= 16'h0041 && c <= 16'h005A) || (c >= 16'h0061 && c <= 16'h007A) ||
			c == 16'h005F;
	endfunction

	function automatic bit blank_char(logic [UnitW-1:0] c);
		return (c >= 16'h0009 && c <= 16'h000D) || c == U_SPACE || c == 16'h0085 ||
			c == 16'h00A0 || c == 16'h1680 || (c >= 16'h2000 && c <= 16'h200A) ||
			c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
			c == 16'h3000;
	endfunction

	function automatic int op_kind(logic [UnitW-1:0] c);
		case (c)
			16'h002B: return TK_PLUS;
			16'h002D, 16'h2013, 16'h2212, 16'h2014: return TK_MINUS;
			16'h002A, 16'h00D7: return TK_MULTIPLY;
			16'h002F, 16'h00F7: return TK_DIVIDE;
			16'h005E: return TK_POWER;
			16'h0028: return TK_LPAREN;
			16'h0029: return TK_RPAREN;
			16'h005B: return TK_LBRACKET;
			16'h005D: return TK_RBRACKET;
			16'h003D: return TK_EQUAL;
			16'h002C: return TK_COMMA;
			default: return -1;
		endcase
	endfunction

	function automatic void restart_scan();
		scan_state = M_IDLE;
		kw_count   = 0;
		tok_start  = 0;
		unit_pos   = 0;
		seen_text  = 1'b0;
		blank_held = 1'b0;
		blank_at   = 0;
	endfunction

	function automatic void push_token(logic [KindW-1:0] kind, longint unsigned off,
		longint unsigned len, logic [ErrW-1:0] err, logic fin);
		result_t r;
		r.kind   = kind;
		r.offset = off[OffW-1:0];
		r.length = len[LenW-1:0];
		r.err    = err;
		r.last   = fin;
		token_queue.push_back(r);
	endfunction

	// ends the open token at stop, 0 when that turns into an error
	function automatic bit close_open(longint unsigned stop);
		logic [KindW-1:0] k;
		case (scan_state)
			M_INT, M_FRAC, M_EXPDIG:
				push_token(TK_NUMBER, tok_start, stop - tok_start, ERR_OK, 1'b0);
			M_DOT: begin
				push_token(TK_NUMBER, tok_start, 0, ERR_DOT_DIGIT, 1'b1);
				return 1'b0;
			end
			M_EXP, M_EXPSIGN: begin
				push_token(TK_NUMBER, tok_start, 0, ERR_EXP_DIGIT, 1'b1);
				return 1'b0;
			end
			M_ID, M_ID_C, M_ID_F: begin
				k = TK_IDENT;
				if (scan_state == M_ID_C && kw_count == KwConstLen) k = TK_CONST;
				if (scan_state == M_ID_F && kw_count == KwFuncLen) k = TK_FUNC;
				push_token(k, tok_start, stop - tok_start, ERR_OK, 1'b0);
			end
			default: ;
		endcase
		scan_state = M_IDLE;
		return 1'b1;
	endfunction

	function automatic bit take_unit(logic [UnitW-1:0] c, longint unsigned off);
		bit held;
		int k;
		held = 1'b0;
		case (scan_state)
			M_INT: begin
				if (num_char(c)) held = 1'b1;
				else if (c == U_DOT) begin
					scan_state = M_DOT;
					held = 1'b1;
				end else if (c == U_E_LO || c == U_E_UP) begin
					scan_state = M_EXP;
					held = 1'b1;
				end
			end
			M_FRAC: begin
				if (num_char(c)) held = 1'b1;
				else if (c == U_E_LO || c == U_E_UP) begin
					scan_state = M_EXP;
					held = 1'b1;
				end
			end
			M_DOT: begin
				if (num_char(c)) begin
					scan_state = M_FRAC;
					held = 1'b1;
				end
			end
			M_EXP: begin
				if (num_char(c)) begin
					scan_state = M_EXPDIG;
					held = 1'b1;
				end else if (c == U_PLUS || c == U_HYPHEN) begin
					scan_state = M_EXPSIGN;
					held = 1'b1;
				end
			end
			M_EXPSIGN, M_EXPDIG: begin
				if (num_char(c)) begin
					scan_state = M_EXPDIG;
					held = 1'b1;
				end
			end
			M_ID, M_ID_C, M_ID_F: begin
				if (num_char(c) || letter_char(c)) begin
					if (scan_state == M_ID_C && kw_count < KwConstLen &&
						c == {8'h00, const_word[kw_count]}) kw_count++;
					else if (scan_state == M_ID_F && kw_count < KwFuncLen &&
						c == {8'h00, func_word[kw_count]}) kw_count++;
					else scan_state = M_ID;
					held = 1'b1;
				end
			end
			default: ;
		endcase
		if (held) return 1'b1;
		if (!close_open(off)) return 1'b0;

		if (c == U_SPACE) return 1'b1;
		if (blank_char(c)) begin
			// other whitespace is only an error if something visible follows
			if (seen_text && !blank_held) begin
				blank_held = 1'b1;
				blank_at   = off;
			end
			return 1'b1;
		end
		if (blank_held) begin
			push_token(TK_NUMBER, blank_at, 0, ERR_BAD_CHAR, 1'b1);
			return 1'b0;
		end
		seen_text = 1'b1;
		if (num_char(c)) begin
			scan_state = M_INT;
			tok_start  = off;
			return 1'b1;
		end
		if (letter_char(c)) begin
			tok_start = off;
			kw_count  = 1;
			if (c == {8'h00, const_word[0]}) scan_state = M_ID_C;
			else if (c == {8'h00, func_word[0]}) scan_state = M_ID_F;
			else scan_state = M_ID;
			return 1'b1;
		end
		k = op_kind(c);
		if (k < 0) begin
			push_token(TK_NUMBER, off, 0, ERR_BAD_CHAR, 1'b1);
			return 1'b0;
		end
		push_token(k[KindW-1:0], off, 1, ERR_OK, 1'b0);
		return 1'b1;
	endfunction

	task automatic predict_tokens(logic [UnitW-1:0] c, logic fin);
		bit ok;
		longint unsigned off;
		if (scan_state == M_SKIP) begin
			if (fin) restart_scan();
			return;
		end
		if (unit_pos >= PosMax) begin
			push_token(TK_NUMBER, PosMax, 0, ERR_TOO_LONG, 1'b1);
			ok = 1'b0;
		end else begin
			off = unit_pos;
			unit_pos++;
			ok = take_unit(c, off);
		end
		if (ok && fin) begin
			if (close_open(unit_pos)) begin
				if (!seen_text) push_token(TK_NUMBER, 0, 0, ERR_EMPTY, 1'b1);
				else push_token(TK_END, unit_pos, 0, ERR_OK, 1'b1);
			end
		end
		if (fin) restart_scan();
		else if (!ok) scan_state = M_SKIP;
	endtask

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want_v);
		$display("%0t ns: token %s got 0x%0h expected 0x%0h", $time, what, got, want_v);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			restart_scan();
			token_queue.delete();
			waiting = 0;
		end else begin
			if (token_ch.valid === 1'b1 && token_ch.ready === 1'b1) begin
				if (token_queue.size() == 0) begin
					report_mismatch("request with none expected, kind", token_ch.token_kind, 0);
				end else begin
					want = token_queue.pop_front();
					if (token_ch.token_kind !== want.kind)
						report_mismatch("token_kind", token_ch.token_kind, want.kind);
					if (token_ch.start_offset !== want.offset)
						report_mismatch("start_offset", token_ch.start_offset, want.offset);
					if (token_ch.token_length !== want.length)
						report_mismatch("token_length", token_ch.token_length, want.length);
					if (token_ch.error_code !== want.err)
						report_mismatch("error_code", token_ch.error_code, want.err);
					if (token_ch.last_token !== want.last)
						report_mismatch("last_token", token_ch.last_token, want.last);
				end
			end
			if (unit_ch.valid === 1'b1 && unit_ch.ready === 1'b1)
				predict_tokens(unit_ch.code_unit, unit_ch.last_unit);
			waiting = token_queue.size();
		end
	end

endmodule

// ----- tb/tb_expression_tokenizer_top.sv -----
`timescale 1ns / 100ps
module tb_expression_tokenizer_top;
	import etok_pkg::*;

	localparam int CycleLimit  = 40000;
	localparam int DrainCycles = 16;
	localparam int RandomUnits = 220;

	// receiver stall patterns
	localparam int RDY_ALWAYS = 0;
	localparam int RDY_MOSTLY = 1;
	localparam int RDY_COIN   = 2;
	localparam int RDY_RARE   = 3;

	localparam logic [UnitW-1:0] U_SPACE = 16'h0020;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   waiting;
	int   cycles = 0;
	int   burst_left = 0;
	int   op_next = 0;
	int   ready_cnt = 0;
	int   ready_mode = RDY_ALWAYS;

	logic [UnitW-1:0] expr_q[$];

	logic [UnitW-1:0] op_units[16] = '{
		16'h002B, 16'h002D, 16'h2013, 16'h2212, 16'h2014, 16'h002A, 16'h00D7, 16'h002F,
		16'h00F7, 16'h005E, 16'h0028, 16'h0029, 16'h005B, 16'h005D, 16'h003D, 16'h002C
	};

	string word_pool[10] = '{
		"const", "func", "co", "fun", "consta", "funcx", "c", "f", "con_st", "Func"
	};

	etok_unit_if  unit_ch();
	etok_token_if token_ch();

	expression_tokenizer_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.unit_ch(unit_ch),
		.token_ch(token_ch)
	);

	etok_token_checker token_check (
		.clk(clk),
		.arst_n(arst_n),
		.unit_ch(unit_ch),
		.token_ch(token_ch),
		.fail_count(fail_count),
		.waiting(waiting)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(negedge clk) begin
		ready_cnt++;
		if (ready_cnt % 48 == 0) ready_mode = $urandom_range(RDY_ALWAYS, RDY_RARE);
		if (!arst_n) token_ch.ready = 1'b0;
		else begin
			case (ready_mode)
				RDY_ALWAYS: token_ch.ready = 1'b1;
				RDY_MOSTLY: token_ch.ready = (ready_cnt % 4) != 0;
				RDY_COIN:   token_ch.ready = 1'($urandom_range(0, 1));
				default:    token_ch.ready = (ready_cnt % 7) < 2;
			endcase
		end
	end

	function automatic logic [UnitW-1:0] blank_unit();
		case ($urandom_range(0, 11))
			0: return 16'($urandom_range(16'h0009, 16'h000D));
			1, 2: return U_SPACE;
			3: return 16'h0085;
			4: return 16'h00A0;
			5: return 16'h1680;
			6: return 16'($urandom_range(16'h2000, 16'h200A));
			7: return 16'h2028;
			8: return 16'h2029;
			9: return 16'h202F;
			10: return 16'h205F;
			default: return 16'h3000;
		endcase
	endfunction

	function automatic logic [UnitW-1:0] word_unit(bit lead);
		int r;
		r = lead ? $urandom_range(0, 52) : $urandom_range(0, 62);
		if (r < 26) return 16'(16'h0061 + r);
		if (r < 52) return 16'(16'h0041 + r - 26);
		if (r == 52) return 16'h005F;
		return 16'(16'h0030 + r - 53);
	endfunction

	function automatic logic [UnitW-1:0] noise_unit();
		case ($urandom_range(0, 5))
			0, 1, 2: return 16'($urandom_range(0, 16'hFFFF));
			3: return blank_unit();
			4: begin
				case ($urandom_range(0, 3))
					0: return 16'h002E;
					1: return 16'h0065;
					2: return 16'h002B;
					default: return 16'h002D;
				endcase
			end
			default: return 16'($urandom_range(16'h0021, 16'h007E));
		endcase
	endfunction

	task automatic add_ascii(string s);
		foreach (s[i]) expr_q.push_back({8'h00, s[i]});
	endtask

	task automatic add_digits(int lo, int hi);
		repeat ($urandom_range(lo, hi)) expr_q.push_back(16'(16'h0030 + $urandom_range(0, 9)));
	endtask

	task automatic add_token();
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				add_digits(1, 4);
				if ($urandom_range(0, 1)) begin
					expr_q.push_back(16'h002E);
					add_digits(1, 3);
				end
				if ($urandom_range(0, 2) == 0) begin
					expr_q.push_back($urandom_range(0, 1) ? 16'h0065 : 16'h0045);
					if ($urandom_range(0, 1))
						expr_q.push_back($urandom_range(0, 1) ? 16'h002B : 16'h002D);
					add_digits(1, 2);
				end
			end
			3, 4, 5: begin
				if ($urandom_range(0, 2) == 0) begin
					expr_q.push_back(word_unit(1'b1));
					repeat ($urandom_range(0, 5)) expr_q.push_back(word_unit(1'b0));
				end else begin
					add_ascii(word_pool[$urandom_range(0, 9)]);
				end
			end
			default: begin
				// sweep every operator once before picking them at random
				if (op_next < 16) expr_q.push_back(op_units[op_next++]);
				else expr_q.push_back(op_units[$urandom_range(0, 15)]);
			end
		endcase
	endtask

	task automatic build_expression();
		int n_tok;
		if ($urandom_range(0, 19) == 0) begin
			repeat ($urandom_range(1, 3)) expr_q.push_back(blank_unit());
			return;
		end
		if ($urandom_range(0, 3) == 0) expr_q.push_back(blank_unit());
		n_tok = $urandom_range(1, 8);
		for (int t = 0; t < n_tok; t++) begin
			if (t > 0) begin
				case ($urandom_range(0, 9))
					5, 6, 7, 8: expr_q.push_back(U_SPACE);
					9: begin
						expr_q.push_back(U_SPACE);
						expr_q.push_back(U_SPACE);
					end
					default: ;
				endcase
			end
			add_token();
		end
		if ($urandom_range(0, 3) == 0) expr_q.push_back(blank_unit());
		// a broken expression now and then
		if ($urandom_range(0, 9) < 3) begin
			repeat ($urandom_range(1, 2))
				expr_q.insert($urandom_range(0, expr_q.size()), noise_unit());
		end
	endtask

	task automatic put_unit(logic [UnitW-1:0] c, logic fin);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				unit_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		unit_ch.valid     = 1'b1;
		unit_ch.code_unit = c;
		unit_ch.last_unit = fin;
		do @(posedge clk); while (unit_ch.ready !== 1'b1);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic send_expression();
		foreach (expr_q[i]) put_unit(expr_q[i], i == expr_q.size() - 1);
		expr_q.delete();
	endtask

	initial begin : stimulus
		int random_units;
		arst_n            = 1'b0;
		unit_ch.valid     = 1'b0;
		unit_ch.code_unit = '0;
		unit_ch.last_unit = 1'b0;
		token_ch.ready    = 1'b0;
		random_units      = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// whitespace only
		expr_q.push_back(16'h0009);
		send_expression();
		// dot as last visible unit
		add_ascii("1.");
		send_expression();
		// exponent sign with no digits
		add_ascii("2e+");
		send_expression();
		// vertical tab between two identifiers
		add_ascii("a");
		expr_q.push_back(16'h000B);
		add_ascii("b");
		send_expression();
		// stray unit, then the rest skipped
		add_ascii("(");
		expr_q.push_back(16'h0000);
		add_ascii(")");
		send_expression();
		expr_q.push_back(16'hFFFF);
		send_expression();
		add_ascii(" const func ");
		send_expression();

		while (random_units < RandomUnits) begin
			build_expression();
			random_units += expr_q.size();
			send_expression();
		end
		unit_ch.valid = 1'b0;

		while (waiting != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
		if (fail_count == 0 && waiting == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
